[hdl/mktd_pkg.sv]
// Shared types, constants and register codes for the Morse key timing decoder.
`default_nettype none

package mktd_pkg;

    localparam int DEF_MAX_ELEMENTS = 8;
    localparam int DEF_COUNT_WIDTH  = 16;

    localparam int CFG_WIDTH      = 16;
    localparam int CFG_ADDR_WIDTH = 3;
    localparam int IN_TDATA_WIDTH  = 8;
    localparam int OUT_TDATA_WIDTH = 16;

    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET  = 16'd30;
    localparam logic [CFG_WIDTH-1:0] MAX_DIT_RESET   = 16'd150;
    localparam logic [CFG_WIDTH-1:0] MAX_DAH_RESET   = 16'd600;
    localparam logic [CFG_WIDTH-1:0] SYMBOL_GAP_RESET = 16'd300;
    localparam logic [CFG_WIDTH-1:0] SPACE_GAP_RESET = 16'd1600;

    typedef enum logic [CFG_ADDR_WIDTH-1:0] {
        CFG_DEBOUNCE   = 3'd0,
        CFG_MAX_DIT    = 3'd1,
        CFG_MAX_DAH    = 3'd2,
        CFG_SYMBOL_GAP = 3'd3,
        CFG_SPACE_GAP  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] debounce_ticks;
        logic [CFG_WIDTH-1:0] max_dit_ticks;
        logic [CFG_WIDTH-1:0] max_dah_ticks;
        logic [CFG_WIDTH-1:0] symbol_gap_ticks;
        logic [CFG_WIDTH-1:0] space_gap_ticks;
    } t_cfg;

    typedef struct packed {
        logic       overflow;
        logic [3:0] pattern_length;
        logic [7:0] pattern_bits;
        logic       is_space;
        logic       symbol_valid;
        logic       tone_on;
    } t_result;

endpackage

`default_nettype wire

[hdl/mktd_cfg_regs.sv]
// Configuration register file for the Morse key timing decoder.
`default_nettype none

module mktd_cfg_regs (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [mktd_pkg::CFG_ADDR_WIDTH-1:0] i_cfg_addr,
    input  wire logic [mktd_pkg::CFG_WIDTH-1:0]      i_cfg_wdata,
    output mktd_pkg::t_cfg                           o_cfg
);

    mktd_pkg::t_cfg r_cfg;
    mktd_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (mktd_pkg::t_cfg_idx'(i_cfg_addr))
                mktd_pkg::CFG_DEBOUNCE:   n_cfg.debounce_ticks   = i_cfg_wdata;
                mktd_pkg::CFG_MAX_DIT:    n_cfg.max_dit_ticks    = i_cfg_wdata;
                mktd_pkg::CFG_MAX_DAH:    n_cfg.max_dah_ticks    = i_cfg_wdata;
                mktd_pkg::CFG_SYMBOL_GAP: n_cfg.symbol_gap_ticks = i_cfg_wdata;
                mktd_pkg::CFG_SPACE_GAP:  n_cfg.space_gap_ticks  = i_cfg_wdata;
                default:                  n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks   <= mktd_pkg::DEBOUNCE_RESET;
            r_cfg.max_dit_ticks    <= mktd_pkg::MAX_DIT_RESET;
            r_cfg.max_dah_ticks    <= mktd_pkg::MAX_DAH_RESET;
            r_cfg.symbol_gap_ticks <= mktd_pkg::SYMBOL_GAP_RESET;
            r_cfg.space_gap_ticks  <= mktd_pkg::SPACE_GAP_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[hdl/mktd_core.sv]
// Timing state and per-tick classification logic of the Morse key timing decoder.
`default_nettype none

module mktd_core #(
    parameter int MAX_ELEMENTS = mktd_pkg::DEF_MAX_ELEMENTS,
    parameter int COUNT_WIDTH  = mktd_pkg::DEF_COUNT_WIDTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  mktd_pkg::t_cfg     i_cfg,
    input  wire logic          i_accept,
    input  wire logic          i_key_level,
    output mktd_pkg::t_result  o_result
);

    localparam int CMP_W = (COUNT_WIDTH > mktd_pkg::CFG_WIDTH) ? COUNT_WIDTH
                                                                : mktd_pkg::CFG_WIDTH;
    localparam logic [3:0] CAPACITY = (MAX_ELEMENTS > 8) ? 4'd8 : 4'(MAX_ELEMENTS);

    logic [COUNT_WIDTH-1:0] r_elapsed;
    logic                   r_last_level;
    logic                   r_paused;
    logic [7:0]             r_bits;
    logic [3:0]             r_count;
    logic                   r_dropped;

    logic [COUNT_WIDTH-1:0] n_elapsed;
    logic                   n_last_level;
    logic                   n_paused;
    logic [7:0]             n_bits;
    logic [3:0]             n_count;
    logic                   n_dropped;

    logic [CMP_W-1:0] m;
    logic             edge_ok;

    always_comb begin
        m = CMP_W'(r_elapsed);
        n_elapsed    = r_elapsed;
        n_last_level = r_last_level;
        n_paused     = r_paused;
        n_bits       = r_bits;
        n_count      = r_count;
        n_dropped    = r_dropped;
        o_result     = '0;
        o_result.tone_on = ~i_key_level;

        if (i_key_level && !r_paused) begin
            if (m > CMP_W'(i_cfg.space_gap_ticks)) begin
                o_result.symbol_valid = 1'b1;
                o_result.is_space     = 1'b1;
                n_bits    = '0;
                n_count   = '0;
                n_dropped = 1'b0;
                n_paused  = 1'b1;
            end else if (m > CMP_W'(i_cfg.symbol_gap_ticks) && r_count != 4'd0) begin
                o_result.symbol_valid   = 1'b1;
                o_result.pattern_bits   = r_bits;
                o_result.pattern_length = r_count;
                o_result.overflow       = r_dropped;
                n_bits    = '0;
                n_count   = '0;
                n_dropped = 1'b0;
            end
        end

        edge_ok = (i_key_level != r_last_level) && (m > CMP_W'(i_cfg.debounce_ticks));
        if (edge_ok) begin
            n_last_level = i_key_level;
            n_elapsed    = '0;
            n_paused     = 1'b0;
            if (i_key_level && !(m > CMP_W'(i_cfg.max_dah_ticks))) begin
                if (n_count < CAPACITY) begin
                    if (m > CMP_W'(i_cfg.max_dit_ticks)) begin
                        n_bits = n_bits | (8'd1 << n_count[2:0]);
                    end
                    n_count = n_count + 4'd1;
                end else begin
                    n_dropped = 1'b1;
                end
            end
        end else if (r_elapsed != {COUNT_WIDTH{1'b1}}) begin
            n_elapsed = r_elapsed + COUNT_WIDTH'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed    <= '0;
            r_last_level <= 1'b1;
            r_paused     <= 1'b0;
            r_bits       <= '0;
            r_count      <= '0;
            r_dropped    <= 1'b0;
        end else if (i_accept) begin
            r_elapsed    <= n_elapsed;
            r_last_level <= n_last_level;
            r_paused     <= n_paused;
            r_bits       <= n_bits;
            r_count      <= n_count;
            r_dropped    <= n_dropped;
        end
    end

endmodule

`default_nettype wire

[hdl/mktd_out_buf.sv]
// Two-entry result buffer that decouples the output request from the input side.
`default_nettype none

module mktd_out_buf (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  mktd_pkg::t_result i_data,
    output logic              o_ready,
    output logic              o_valid,
    input  wire logic         i_pop_ready,
    output mktd_pkg::t_result o_data
);

    localparam logic [1:0] DEPTH = 2'd2;

    mktd_pkg::t_result r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_count;
    logic       pop;

    assign o_ready = (r_count != DEPTH);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, i_push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

[hdl/morse_key_timing_decoder_unit.sv]
// Top level of the Morse key timing decoder.
// The result of an accepted tick request is registered into the result buffer.
// Throughput: one tick request per clock cycle while the result buffer is not full.
// A two-entry result buffer keeps input accepted while one result waits.
// Reset is synchronous and active low; it clears the timing state and the result
// buffer and loads the default thresholds into the configuration registers.
`default_nettype none

module morse_key_timing_decoder_unit #(
    parameter int MAX_ELEMENTS = mktd_pkg::DEF_MAX_ELEMENTS,
    parameter int COUNT_WIDTH  = mktd_pkg::DEF_COUNT_WIDTH
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [mktd_pkg::CFG_ADDR_WIDTH-1:0]  i_cfg_addr,
    input  wire logic [mktd_pkg::CFG_WIDTH-1:0]       i_cfg_wdata,
    input  wire logic                                 i_s_axis_tvalid,
    output logic                                      o_s_axis_tready,
    // Fields from bit 0: key_level, then zero fill.
    input  wire logic [mktd_pkg::IN_TDATA_WIDTH-1:0]  i_s_axis_tdata,
    output logic                                      o_m_axis_tvalid,
    input  wire logic                                 i_m_axis_tready,
    // Fields from bit 0: tone_on, symbol_valid, is_space, pattern_bits[7:0],
    // pattern_length[3:0], overflow.
    output logic [mktd_pkg::OUT_TDATA_WIDTH-1:0]      o_m_axis_tdata
);

    mktd_pkg::t_cfg    cfg;
    mktd_pkg::t_result core_result;
    mktd_pkg::t_result buf_result;
    logic              accept;

    assign accept = i_s_axis_tvalid && o_s_axis_tready;

    mktd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    mktd_core #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_accept    (accept),
        .i_key_level (i_s_axis_tdata[0]),
        .o_result    (core_result)
    );

    mktd_out_buf u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_data      (core_result),
        .o_ready     (o_s_axis_tready),
        .o_valid     (o_m_axis_tvalid),
        .i_pop_ready (i_m_axis_tready),
        .o_data      (buf_result)
    );

    assign o_m_axis_tdata = buf_result;

endmodule

`default_nettype wire

[hdl/mktd_checker.sv]
// Port-level checker for the Morse key timing decoder and its bind statement.
`default_nettype none

module mktd_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                o_m_axis_tvalid,
    input wire logic                                i_m_axis_tready,
    input wire logic [mktd_pkg::OUT_TDATA_WIDTH-1:0] o_m_axis_tdata
);

    mktd_pkg::t_result res;
    assign res = o_m_axis_tdata;

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result request valid right after reset");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result request changed");

    a_no_symbol_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !res.symbol_valid |->
            !res.is_space && res.pattern_bits == 8'd0 &&
            res.pattern_length == 4'd0 && !res.overflow)
        else $error("symbol fields set without a symbol");

    a_space_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && res.is_space |->
            res.symbol_valid && res.pattern_bits == 8'd0 &&
            res.pattern_length == 4'd0 && !res.overflow)
        else $error("space marker carries pattern fields");

    a_pattern_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && res.symbol_valid && !res.is_space |->
            res.pattern_length != 4'd0 && res.pattern_length <= 4'd8)
        else $error("emitted pattern length out of range");

endmodule

bind morse_key_timing_decoder_unit mktd_checker u_mktd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire

[tb/morse_symbol_checker.sv]
// Checker that predicts every decoder result from the observed requests and compares them.
module morse_symbol_checker (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [mktd_pkg::CFG_ADDR_WIDTH-1:0]  i_cfg_addr,
    input  wire logic [mktd_pkg::CFG_WIDTH-1:0]       i_cfg_wdata,
    input  wire logic                                 i_s_axis_tvalid,
    input  wire logic                                 i_s_axis_tready,
    // Fields from bit 0: key_level, then zero fill.
    input  wire logic [mktd_pkg::IN_TDATA_WIDTH-1:0]  i_s_axis_tdata,
    input  wire logic                                 i_m_axis_tvalid,
    input  wire logic                                 i_m_axis_tready,
    // Fields from bit 0: tone_on, symbol_valid, is_space, pattern_bits[7:0],
    // pattern_length[3:0], overflow.
    input  wire logic [mktd_pkg::OUT_TDATA_WIDTH-1:0] i_m_axis_tdata,
    output int                                        o_pending,
    output int                                        o_errors
);

    localparam int ELEMENT_CAP = (mktd_pkg::DEF_MAX_ELEMENTS > 8) ? 8
                                                                   : mktd_pkg::DEF_MAX_ELEMENTS;
    localparam logic [mktd_pkg::DEF_COUNT_WIDTH-1:0] ELAPSED_MAX = '1;
    localparam int REPORT_LIMIT = 10;

    mktd_pkg::t_cfg                       thr;
    logic [mktd_pkg::DEF_COUNT_WIDTH-1:0] elapsed;
    logic                                 held_level;
    logic                                 paused;
    logic [7:0]                           elem_bits;
    logic [3:0]                           elem_count;
    logic                                 elem_dropped;
    mktd_pkg::t_result                    tick_results_due[$];
    mktd_pkg::t_result                    got;
    mktd_pkg::t_result                    want;
    int                                   mismatches = 0;

    function automatic void clear_elements();
        elem_bits = '0;
        elem_count = '0;
        elem_dropped = 1'b0;
    endfunction

    function automatic mktd_pkg::t_result decode_tick(input logic key);
        logic [mktd_pkg::DEF_COUNT_WIDTH-1:0] m;
        mktd_pkg::t_result r;
        m = elapsed;
        r = '0;
        r.tone_on = ~key;
        if (key && !paused) begin
            if (m > thr.space_gap_ticks) begin
                r.symbol_valid = 1'b1;
                r.is_space = 1'b1;
                clear_elements();
                paused = 1'b1;
            end else if (m > thr.symbol_gap_ticks && elem_count != 0) begin
                r.symbol_valid = 1'b1;
                r.pattern_bits = elem_bits;
                r.pattern_length = elem_count;
                r.overflow = elem_dropped;
                clear_elements();
            end
        end
        if (key != held_level && m > thr.debounce_ticks) begin
            held_level = key;
            elapsed = '0;
            paused = 1'b0;
            if (key && m <= thr.max_dah_ticks) begin
                if (elem_count < ELEMENT_CAP) begin
                    elem_bits[elem_count] = (m > thr.max_dit_ticks);
                    elem_count = elem_count + 1'b1;
                end else begin
                    elem_dropped = 1'b1;
                end
            end
        end else if (elapsed != ELAPSED_MAX) begin
            elapsed = elapsed + 1'b1;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            thr = '{debounce_ticks: mktd_pkg::DEBOUNCE_RESET,
                    max_dit_ticks: mktd_pkg::MAX_DIT_RESET,
                    max_dah_ticks: mktd_pkg::MAX_DAH_RESET,
                    symbol_gap_ticks: mktd_pkg::SYMBOL_GAP_RESET,
                    space_gap_ticks: mktd_pkg::SPACE_GAP_RESET};
            elapsed = '0;
            held_level = 1'b1;
            paused = 1'b0;
            clear_elements();
            tick_results_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    mktd_pkg::CFG_DEBOUNCE:   thr.debounce_ticks = i_cfg_wdata;
                    mktd_pkg::CFG_MAX_DIT:    thr.max_dit_ticks = i_cfg_wdata;
                    mktd_pkg::CFG_MAX_DAH:    thr.max_dah_ticks = i_cfg_wdata;
                    mktd_pkg::CFG_SYMBOL_GAP: thr.symbol_gap_ticks = i_cfg_wdata;
                    mktd_pkg::CFG_SPACE_GAP:  thr.space_gap_ticks = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                tick_results_due.push_back(decode_tick(i_s_axis_tdata[0]));
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got = mktd_pkg::t_result'(i_m_axis_tdata);
                if (tick_results_due.size() == 0) begin
                    if (mismatches < REPORT_LIMIT) begin
                        $display("unexpected result %h with no request pending", got);
                    end
                    mismatches++;
                end else begin
                    want = tick_results_due.pop_front();
                    if (got.tone_on !== want.tone_on
                            || got.symbol_valid !== want.symbol_valid
                            || got.is_space !== want.is_space
                            || got.pattern_bits !== want.pattern_bits
                            || got.pattern_length !== want.pattern_length
                            || got.overflow !== want.overflow) begin
                        if (mismatches < REPORT_LIMIT) begin
                            $display({"mismatch: expected tone %b valid %b space %b bits %h ",
                                      "len %0d ovf %b, got tone %b valid %b space %b ",
                                      "bits %h len %0d ovf %b"},
                                     want.tone_on, want.symbol_valid, want.is_space,
                                     want.pattern_bits, want.pattern_length, want.overflow,
                                     got.tone_on, got.symbol_valid, got.is_space,
                                     got.pattern_bits, got.pattern_length, got.overflow);
                        end
                        mismatches++;
                    end
                end
            end
        end
        o_pending <= tick_results_due.size();
        o_errors <= mismatches;
    end

endmodule

[tb/morse_key_timing_decoder_unit_tb.sv]
// Stimulus and verdict for the Morse key timing decoder, checked by morse_symbol_checker.
module morse_key_timing_decoder_unit_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 4;
    localparam logic [mktd_pkg::CFG_ADDR_WIDTH-1:0] CFG_UNMAPPED = 3'd7;
    localparam logic KEY_DOWN = 1'b0;
    localparam logic KEY_UP = 1'b1;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 cfg_we = 1'b0;
    logic [mktd_pkg::CFG_ADDR_WIDTH-1:0]  cfg_addr = '0;
    logic [mktd_pkg::CFG_WIDTH-1:0]       cfg_wdata = '0;
    logic                                 s_tvalid = 1'b0;
    logic [mktd_pkg::IN_TDATA_WIDTH-1:0]  s_tdata = '0;
    logic                                 m_tready = 1'b0;
    logic                                 o_s_axis_tready;
    logic                                 o_m_axis_tvalid;
    logic [mktd_pkg::OUT_TDATA_WIDTH-1:0] o_m_axis_tdata;

    int pending;
    int errors;
    int stall_cycles = 0;
    int src_idle_pct = 31;
    int rcv_idle_pct = 50;
    int ticks_sent = 0;
    int db_t, dit_t, dah_t, sym_t, spc_t;

    morse_key_timing_decoder_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    morse_symbol_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .o_pending       (pending),
        .o_errors        (errors)
    );

    always #6 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_tick(input logic lvl);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(mktd_pkg::IN_TDATA_WIDTH-1){1'b0}}, lvl};
        do @(posedge i_clk); while (!o_s_axis_tready);
        ticks_sent++;
    endtask

    task automatic send_run(input logic lvl, input int n);
        repeat (n) send_tick(lvl);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [mktd_pkg::CFG_ADDR_WIDTH-1:0] idx, input int val);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val[mktd_pkg::CFG_WIDTH-1:0];
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic program_timing(input int db, input int dt, input int dh, input int sg,
                                  input int sp);
        write_reg(mktd_pkg::CFG_DEBOUNCE, db);
        write_reg(mktd_pkg::CFG_MAX_DIT, dt);
        write_reg(mktd_pkg::CFG_MAX_DAH, dh);
        write_reg(mktd_pkg::CFG_SYMBOL_GAP, sg);
        write_reg(mktd_pkg::CFG_SPACE_GAP, sp);
        db_t = db;
        dit_t = dt;
        dah_t = dh;
        sym_t = sg;
        spc_t = sp;
    endtask

    // One keyed letter: presses sized around the dit and dah limits, sometimes with a
    // contact bounce, then a letter or word gap.
    task automatic send_letter();
        int n_elem;
        int r;
        int len;
        n_elem = ($urandom_range(99) < 30) ? $urandom_range(5, 11) : $urandom_range(1, 4);
        for (int i = 0; i < n_elem; i++) begin
            r = $urandom_range(99);
            if (r < 45) begin
                len = $urandom_range(db_t + 2, dit_t + 2);
            end else if (r < 90) begin
                len = $urandom_range(dit_t + 3, dah_t + 2);
            end else begin
                len = $urandom_range(dah_t + 3, spc_t + 4);
            end
            if (db_t > 0 && $urandom_range(99) < 15) begin
                send_run(KEY_DOWN, len / 2 + 1);
                send_run(KEY_UP, $urandom_range(1, db_t));
                send_run(KEY_DOWN, len / 2);
            end else begin
                send_run(KEY_DOWN, len);
            end
            if (i < n_elem - 1) begin
                send_run(KEY_UP, $urandom_range(db_t + 2, sym_t + 1));
            end
        end
        if ($urandom_range(99) < 60) begin
            send_run(KEY_UP, $urandom_range(sym_t + 2, spc_t + 1));
        end else begin
            send_run(KEY_UP, $urandom_range(spc_t + 2, spc_t + 10));
        end
    endtask

    task automatic send_traffic(input int n_ticks);
        int start;
        start = ticks_sent;
        while (ticks_sent - start < n_ticks) begin
            if ($urandom_range(99) < 85) begin
                send_letter();
            end else begin
                repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // A few ticks with the reset thresholds still in place.
        send_run(KEY_UP, 3);
        send_run(KEY_DOWN, 3);
        drain_results();
        write_reg(CFG_UNMAPPED, 16'hFFFF);

        program_timing(0, 1, 4, 2, 5);
        send_run(KEY_DOWN, 3);
        send_run(KEY_UP, 2);
        // Held past the symbol gap with a dah pending, so the release emits first.
        send_run(KEY_DOWN, 5);
        send_run(KEY_UP, 2);
        // Held past both the dah limit and the space gap with elements pending.
        send_run(KEY_DOWN, 8);
        send_run(KEY_UP, 7);
        drain_results();

        program_timing(1, 3, 7, 5, 12);
        send_traffic(170);
        drain_results();
        send_traffic(170);
        drain_results();

        src_idle_pct = 50;
        rcv_idle_pct = 31;
        program_timing(0, 2, 5, 4, 9);
        send_traffic(290);
        drain_results();

        src_idle_pct = 0;
        rcv_idle_pct = 0;
        // Space gap below the symbol gap, so pending letters are lost to spaces.
        program_timing(2, 4, 8, 10, 7);
        send_traffic(210);
        drain_results();

        program_timing(0, 0, 0, 0, 0);
        repeat (100) send_tick(1'($urandom_range(0, 1)));
        send_run(KEY_UP, 4);
        drain_results();

        if (errors == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
